// File: sv/modular_arithmetic_unit_32_macros.svh
// Assertion helpers shared by the controller and the datapath.
// Both expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef MODULAR_ARITHMETIC_UNIT_32_MACROS_SVH
`define MODULAR_ARITHMETIC_UNIT_32_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define MAU32_CHECK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MAU32_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/mau32_pkg.sv
`timescale 1ns / 1ps

package mau32_pkg;

  localparam int CMD_W     = 3;
  localparam int OPA_W     = 31;
  localparam int OPB_W     = 63;
  localparam int RES_W     = 31;
  localparam int EXP_BITS  = 63;
  localparam int RED_STEPS = OPB_W;
  localparam int CNT_W     = $clog2(RED_STEPS);

  localparam logic [RES_W-1:0] MOD_RESET = RES_W'(1000000007);
  localparam logic [OPB_W-1:0] EXP_MASK  = {OPB_W{1'b1}} >> (OPB_W - EXP_BITS);

  // command codes
  localparam logic [CMD_W-1:0] OP_ADD = 3'd0;
  localparam logic [CMD_W-1:0] OP_SUB = 3'd1;
  localparam logic [CMD_W-1:0] OP_MUL = 3'd2;
  localparam logic [CMD_W-1:0] OP_DIV = 3'd3;
  localparam logic [CMD_W-1:0] OP_NEG = 3'd4;
  localparam logic [CMD_W-1:0] OP_INV = 3'd5;
  localparam logic [CMD_W-1:0] OP_POW = 3'd6;

  // reducer load source
  localparam logic [1:0] SRC_A    = 2'd0;
  localparam logic [1:0] SRC_B    = 2'd1;
  localparam logic [1:0] SRC_PROD = 2'd2;

  // multiplier operand pairs
  localparam logic [1:0] MS_AB     = 2'd0;
  localparam logic [1:0] MS_ACC_SQ = 2'd1;
  localparam logic [1:0] MS_SQ_SQ  = 2'd2;
  localparam logic [1:0] MS_A_ACC  = 2'd3;

  // reducer write-back destinations
  localparam logic [1:0] DST_AR  = 2'd0;
  localparam logic [1:0] DST_BR  = 2'd1;
  localparam logic [1:0] DST_ACC = 2'd2;
  localparam logic [1:0] DST_SQ  = 2'd3;

  typedef struct packed {
    logic             cap;
    logic             red_load;
    logic [1:0]       red_src;
    logic [1:0]       mul_sel;
    logic             red_step;
    logic             wr_en;
    logic [1:0]       wr_dst;
    logic             pow_init;
    logic             pow_base_b;
    logic             pow_fermat;
    logic             exp_shift;
    logic             fin;
    logic [CMD_W-1:0] op;
  } mau32_cmd_t;

  typedef struct packed {
    logic ar_zero;
    logic br_zero;
    logic exp_zero;
    logic exp_lsb;
  } mau32_sts_t;

endpackage

// File: sv/mau32_dp.sv
`timescale 1ns / 1ps

module mau32_dp import mau32_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [RES_W-1:0] cfg_wr_data,
  input  logic [OPA_W-1:0] in_operand_a,
  input  logic [OPB_W-1:0] in_operand_b,
  input  mau32_cmd_t       cmd,
  output mau32_sts_t       sts,
  output logic [RES_W-1:0] out_result,
  output logic             out_error
);

  `include "modular_arithmetic_unit_32_macros.svh"

  logic [RES_W-1:0]   modulus_r;
  logic [RES_W-1:0]   m_eff;
  logic               m_one;
  logic [OPB_W-1:0]   b_raw_r;
  logic [RES_W-1:0]   ar_r, br_r, acc_r, sq_r;
  logic [OPB_W-1:0]   exp_r;
  logic [OPB_W-1:0]   val_r;
  logic [RES_W-1:0]   rem_r;
  logic [RES_W-1:0]   result_r;
  logic               error_r;

  logic [RES_W-1:0]   mul_x, mul_y;
  logic [2*RES_W-1:0] prod;
  logic [OPB_W-1:0]   val_load;
  logic [RES_W:0]     rem_t;
  logic [RES_W-1:0]   rem_step;
  logic [RES_W:0]     add_s;
  logic [RES_W-1:0]   res_fin;
  logic               zero_div;
  logic               err_fin;

  assign m_one = (modulus_r < RES_W'(2));
  assign m_eff = m_one ? RES_W'(1) : modulus_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MOD_RESET;
    end else if (cfg_wr_en) begin
      modulus_r <= cfg_wr_data;
    end
  end

  // one shared multiplier, registered into the reducer
  always_comb begin
    case (cmd.mul_sel)
      MS_AB:     begin mul_x = ar_r; mul_y = br_r;  end
      MS_ACC_SQ: begin mul_x = acc_r; mul_y = sq_r; end
      MS_SQ_SQ:  begin mul_x = sq_r; mul_y = sq_r;  end
      MS_A_ACC:  begin mul_x = ar_r; mul_y = acc_r; end
      default:   begin mul_x = ar_r; mul_y = br_r;  end
    endcase
    prod = mul_x * mul_y;
  end

  always_comb begin
    case (cmd.red_src)
      SRC_A:    val_load = {{(OPB_W-OPA_W){1'b0}}, in_operand_a};
      SRC_B:    val_load = b_raw_r;
      SRC_PROD: val_load = {{(OPB_W-2*RES_W){1'b0}}, prod};
      default:  val_load = b_raw_r;
    endcase
  end

  // restoring reduction: shift in one bit, subtract the modulus if it fits
  always_comb begin
    rem_t    = {rem_r, val_r[OPB_W-1]};
    rem_step = (rem_t >= {1'b0, m_eff}) ? RES_W'(rem_t - {1'b0, m_eff}) : rem_t[RES_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      b_raw_r <= in_operand_b;
    end
    if (cmd.red_load) begin
      val_r <= val_load;
      rem_r <= '0;
    end else if (cmd.red_step) begin
      val_r <= {val_r[OPB_W-2:0], 1'b0};
      rem_r <= rem_step;
    end
    if (cmd.wr_en) begin
      case (cmd.wr_dst)
        DST_AR:  ar_r  <= rem_step;
        DST_BR:  br_r  <= rem_step;
        DST_ACC: acc_r <= rem_step;
        DST_SQ:  sq_r  <= rem_step;
        default: acc_r <= rem_step;
      endcase
    end
    if (cmd.pow_init) begin
      acc_r <= m_one ? RES_W'(0) : RES_W'(1);
      sq_r  <= cmd.pow_base_b ? br_r : ar_r;
      exp_r <= cmd.pow_fermat ? {{(OPB_W-RES_W){1'b0}}, RES_W'(m_eff - RES_W'(2))}
                              : (b_raw_r & EXP_MASK);
    end else if (cmd.exp_shift) begin
      exp_r <= {1'b0, exp_r[OPB_W-1:1]};
    end
    if (cmd.fin) begin
      result_r <= res_fin;
      error_r  <= err_fin;
    end
  end

  always_comb begin
    add_s    = {1'b0, ar_r} + {1'b0, br_r};
    zero_div = ((cmd.op == OP_DIV) && (br_r == '0)) || ((cmd.op == OP_INV) && (ar_r == '0));
    err_fin  = zero_div && !m_one;
    case (cmd.op)
      OP_ADD: res_fin = (add_s >= {1'b0, m_eff}) ? RES_W'(add_s - {1'b0, m_eff})
                                                  : add_s[RES_W-1:0];
      OP_SUB: res_fin = (ar_r >= br_r) ? (ar_r - br_r) : (ar_r + (m_eff - br_r));
      OP_NEG: res_fin = (ar_r == '0) ? RES_W'(0) : (m_eff - ar_r);
      OP_MUL, OP_POW: res_fin = acc_r;
      OP_DIV, OP_INV: res_fin = zero_div ? RES_W'(0) : acc_r;
      default: res_fin = '0;
    endcase
  end

  assign sts.ar_zero  = (ar_r == '0);
  assign sts.br_zero  = (br_r == '0);
  assign sts.exp_zero = (exp_r == '0);
  assign sts.exp_lsb  = exp_r[0];

  assign out_result = result_r;
  assign out_error  = error_r;

  `MAU32_CHECK_NOW(a_rem_below_mod, cmd.red_step, rem_r < m_eff, "partial remainder not reduced")
  `MAU32_CHECK_NEXT(a_result_below_mod, cmd.fin, result_r < m_eff, "result not a residue")
  `MAU32_CHECK_NOW(a_shift_nonzero_exp, cmd.exp_shift, !sts.exp_zero, "exponent shifted after end")

endmodule

// File: sv/mau32_ctrl.sv
`timescale 1ns / 1ps

module mau32_ctrl import mau32_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [CMD_W-1:0] in_command,
  output logic             out_valid,
  input  logic             out_stall,
  input  mau32_sts_t       sts,
  output mau32_cmd_t       cmd
);

  `include "modular_arithmetic_unit_32_macros.svh"

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_RA      = 4'd1;
  localparam logic [3:0] S_RB      = 4'd2;
  localparam logic [3:0] S_DISP    = 4'd3;
  localparam logic [3:0] S_PW_TEST = 4'd4;
  localparam logic [3:0] S_PW_MA   = 4'd5;
  localparam logic [3:0] S_PW_SQ   = 4'd6;
  localparam logic [3:0] S_FMUL    = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CMD_W-1:0] op_r, op_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             red_last;

  assign red_last = (cnt_r == CNT_W'(RED_STEPS - 1));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    op_nxt    = op_r;
    cmd       = '0;
    cmd.op    = op_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap      = 1'b1;
          cmd.red_load = 1'b1;
          cmd.red_src  = SRC_A;
          op_nxt       = in_command;
          cnt_nxt      = '0;
          state_nxt    = S_RA;
        end
      end
      S_RA: begin
        cmd.red_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (red_last) begin
          cmd.wr_en    = 1'b1;
          cmd.wr_dst   = DST_AR;
          cmd.red_load = 1'b1;
          cmd.red_src  = SRC_B;
          cnt_nxt      = '0;
          state_nxt    = S_RB;
        end
      end
      S_RB: begin
        cmd.red_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (red_last) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_dst = DST_BR;
          cnt_nxt    = '0;
          state_nxt  = S_DISP;
        end
      end
      S_DISP: begin
        cnt_nxt = '0;
        case (op_r)
          OP_MUL: begin
            cmd.red_load = 1'b1;
            cmd.red_src  = SRC_PROD;
            cmd.mul_sel  = MS_AB;
            state_nxt    = S_FMUL;
          end
          OP_DIV: begin
            if (sts.br_zero) begin
              state_nxt = S_DONE;
            end else begin
              cmd.pow_init   = 1'b1;
              cmd.pow_base_b = 1'b1;
              cmd.pow_fermat = 1'b1;
              state_nxt      = S_PW_TEST;
            end
          end
          OP_INV: begin
            if (sts.ar_zero) begin
              state_nxt = S_DONE;
            end else begin
              cmd.pow_init   = 1'b1;
              cmd.pow_fermat = 1'b1;
              state_nxt      = S_PW_TEST;
            end
          end
          OP_POW: begin
            cmd.pow_init = 1'b1;
            state_nxt    = S_PW_TEST;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_PW_TEST: begin
        cnt_nxt      = '0;
        cmd.red_load = 1'b1;
        cmd.red_src  = SRC_PROD;
        if (sts.exp_zero) begin
          // divide still needs the dividend times the inverse
          if (op_r == OP_DIV) begin
            cmd.mul_sel = MS_A_ACC;
            state_nxt   = S_FMUL;
          end else begin
            cmd.red_load = 1'b0;
            state_nxt    = S_DONE;
          end
        end else if (sts.exp_lsb) begin
          cmd.mul_sel = MS_ACC_SQ;
          state_nxt   = S_PW_MA;
        end else begin
          cmd.mul_sel = MS_SQ_SQ;
          state_nxt   = S_PW_SQ;
        end
      end
      S_PW_MA: begin
        cmd.red_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (red_last) begin
          cmd.wr_en    = 1'b1;
          cmd.wr_dst   = DST_ACC;
          cmd.red_load = 1'b1;
          cmd.red_src  = SRC_PROD;
          cmd.mul_sel  = MS_SQ_SQ;
          cnt_nxt      = '0;
          state_nxt    = S_PW_SQ;
        end
      end
      S_PW_SQ: begin
        cmd.red_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (red_last) begin
          cmd.wr_en     = 1'b1;
          cmd.wr_dst    = DST_SQ;
          cmd.exp_shift = 1'b1;
          cnt_nxt       = '0;
          state_nxt     = S_PW_TEST;
        end
      end
      S_FMUL: begin
        cmd.red_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (red_last) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_dst = DST_ACC;
          cnt_nxt    = '0;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free or being drained
        if (!out_valid_r || !out_stall) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.fin) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      op_r        <= OP_ADD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  `MAU32_CHECK_NOW(a_cnt_in_range, 1'b1, cnt_r < CNT_W'(RED_STEPS), "step count overran")
  `MAU32_CHECK_NEXT(a_fin_sets_valid, cmd.fin, out_valid_r, "result transfer lost")
  `MAU32_CHECK_NOW(a_wb_on_last, cmd.wr_en, cmd.red_step && red_last, "early write-back")

endmodule

// File: sv/modular_arithmetic_unit_32.sv
// Modular arithmetic unit: add, subtract, multiply, divide, negate, inverse
// and power of residues over the programmable modulus (inverse by Fermat).
// Input channel in_valid/in_stall carries command, operand_a, operand_b;
// result channel out_valid/out_stall carries result and error. A transfer
// happens on a clock edge with valid high and stall low. cfg_wr_en writes
// the modulus from cfg_wr_data; write only while the unit is idle.
// One item is worked at a time. Every operand reduction and every modular
// product runs through a bit-serial shift-subtract reducer, fed by one
// 31x31 multiplier. Inverse is worked as a power with exponent modulus-2;
// divide is that inverse of operand_b multiplied by the reduced operand_a.
// in_stall drops on the edge that loads the result, so the next item may
// transfer in the following cycle. A finished result waits in the output
// register while out_stall is high; the unit holds in its last state
// until the register drains. Reset (rst_n, synchronous, low) empties
// the output, returns to idle and sets the modulus to 1000000007; no
// clearing pass.
`timescale 1ns / 1ps

module modular_arithmetic_unit_32 import mau32_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [CMD_W-1:0] in_command,
  input  logic [OPA_W-1:0] in_operand_a,
  input  logic [OPB_W-1:0] in_operand_b,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [RES_W-1:0] out_result,
  output logic             out_error,
  input  logic             cfg_wr_en,
  input  logic [RES_W-1:0] cfg_wr_data
);

  mau32_cmd_t dp_cmd;
  mau32_sts_t dp_sts;

  mau32_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sts        (dp_sts),
    .cmd        (dp_cmd)
  );

  mau32_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .cmd          (dp_cmd),
    .sts          (dp_sts),
    .out_result   (out_result),
    .out_error    (out_error)
  );

endmodule

// File: test/tb_modular_arithmetic_unit_32.sv
`timescale 1ns / 1ps

module tb_modular_arithmetic_unit_32 import mau32_pkg::*; ();

  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam logic [RES_W-1:0] MOD_MAX    = 31'h7FFF_FFFF;
  localparam logic [OPA_W-1:0] A_MAX      = 31'h7FFF_FFFF;
  localparam logic [OPB_W-1:0] B_MAX      = 63'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [OPB_W-1:0] B_TOP      = 63'h4000_0000_0000_0000;
  localparam int NUM_VECTORS    = 25;
  localparam int NUM_PHASES     = 9;
  localparam int HOLD_CYCLES    = 500;
  localparam int TAIL_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 40000;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [RES_W-1:0] residue;
    logic             error;
  } residue_t;

  typedef struct packed {
    logic [RES_W-1:0] modulus;
    logic [CMD_W-1:0] cmd;
    logic [OPA_W-1:0] a;
    logic [OPB_W-1:0] b;
    logic             typed;
    logic [RES_W-1:0] residue;
    logic             error;
  } vector_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [CMD_W-1:0] in_command;
  logic [OPA_W-1:0] in_operand_a;
  logic [OPB_W-1:0] in_operand_b;
  logic             out_valid;
  logic             out_stall;
  logic [RES_W-1:0] out_result;
  logic             out_error;
  logic             cfg_wr_en;
  logic [RES_W-1:0] cfg_wr_data;

  residue_t         pending_residues [$];
  logic [RES_W-1:0] modulus_now = MOD_RESET;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int holds_asked   = 0;
  int holds_served  = 0;
  int quiet_cycles  = 0;
  int mismatches    = 0;
  int results_seen  = 0;
  int items_sent    = 0;
  int modulus_writes = 0;
  int cmd_count [8] = '{default: 0};

  // Directed items: typed expectations only where the answer is obvious.
  vector_t vectors [NUM_VECTORS] = '{
    '{MOD_RESET, OP_ADD, 0, 0, 1, 0, 0},
    '{MOD_RESET, OP_ADD, A_MAX, B_MAX, 0, 0, 0},
    '{MOD_RESET, OP_SUB, 0, 1, 1, 1000000006, 0},
    '{MOD_RESET, OP_MUL, A_MAX, B_MAX, 0, 0, 0},
    '{MOD_RESET, OP_MUL, 1000000006, 1000000006, 1, 1, 0},
    '{MOD_RESET, OP_DIV, 5, 0, 1, 0, 1},
    '{MOD_RESET, OP_DIV, 7, 1000000007, 1, 0, 1},
    '{MOD_RESET, OP_DIV, 10, 2, 1, 5, 0},
    '{MOD_RESET, OP_NEG, 0, B_MAX, 1, 0, 0},
    '{MOD_RESET, OP_NEG, 1, 0, 1, 1000000006, 0},
    '{MOD_RESET, OP_INV, 0, 0, 1, 0, 1},
    '{MOD_RESET, OP_INV, 1, 0, 1, 1, 0},
    '{MOD_RESET, OP_POW, 0, 0, 1, 1, 0},
    '{MOD_RESET, OP_POW, 2, 10, 1, 1024, 0},
    '{MOD_RESET, OP_POW, 3, B_MAX, 0, 0, 0},
    '{MOD_RESET, OP_POW, A_MAX, B_TOP, 0, 0, 0},
    '{MOD_RESET, CMD_UNUSED, A_MAX, B_MAX, 1, 0, 0},
    '{1, OP_MUL, 12345, 678, 1, 0, 0},
    '{0, OP_POW, 7, 0, 1, 0, 0},
    '{1000, OP_INV, 3, 0, 0, 0, 0},
    '{1000, OP_DIV, 7, 2000, 1, 0, 1},
    '{2, OP_ADD, 1, 1, 1, 0, 0},
    '{MOD_MAX, OP_INV, A_MAX, 0, 1, 0, 1},
    '{MOD_MAX, OP_NEG, 1, 0, 1, 31'h7FFF_FFFE, 0},
    '{MOD_MAX, OP_INV, 2, 0, 0, 0, 0}
  };

  logic [RES_W-1:0] phase_modulus [NUM_PHASES] =
    '{MOD_RESET, 13, MOD_MAX, 65521, 998244353, 2, 1000, 1, 0};
  int phase_items [NUM_PHASES] = '{250, 200, 200, 200, 200, 100, 50, 25, 25};

  modular_arithmetic_unit_32 uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_result   (out_result),
    .out_error    (out_error),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned mulmod(input longint unsigned x, input longint unsigned y,
                                             input longint unsigned m);
    return (x * y) % m;
  endfunction

  function automatic longint unsigned powmod(input longint unsigned base,
                                             input logic [OPB_W-1:0] expo,
                                             input longint unsigned m);
    longint unsigned acc;
    longint unsigned sq;
    logic [OPB_W-1:0] e;
    acc = 1 % m;
    sq  = base % m;
    e   = expo;
    while (e != '0) begin
      if (e[0]) acc = mulmod(acc, sq, m);
      sq = mulmod(sq, sq, m);
      e  = e >> 1;
    end
    return acc;
  endfunction

  function automatic residue_t predict_residue(input logic [CMD_W-1:0] cmd,
                                               input logic [OPA_W-1:0] a,
                                               input logic [OPB_W-1:0] b,
                                               input logic [RES_W-1:0] modulus);
    longint unsigned m;
    longint unsigned ar;
    longint unsigned br;
    longint unsigned fermat;
    residue_t r;
    // a modulus of zero or one behaves as one
    m      = (modulus < 2) ? 64'd1 : 64'(modulus);
    ar     = a % m;
    br     = b % m;
    fermat = (m >= 2) ? m - 2 : 0;
    r.cmd     = cmd;
    r.residue = '0;
    r.error   = 1'b0;
    case (cmd)
      OP_ADD: r.residue = RES_W'((ar + br) % m);
      OP_SUB: r.residue = RES_W'((ar + m - br) % m);
      OP_MUL: r.residue = RES_W'(mulmod(ar, br, m));
      OP_DIV: begin
        if (br == 0) r.error = (m >= 2);
        else r.residue = RES_W'(mulmod(ar, powmod(br, OPB_W'(fermat), m), m));
      end
      OP_NEG: r.residue = RES_W'((m - ar) % m);
      OP_INV: begin
        if (ar == 0) r.error = (m >= 2);
        else r.residue = RES_W'(powmod(ar, OPB_W'(fermat), m));
      end
      OP_POW: r.residue = RES_W'(powmod(ar, b & EXP_MASK, m));
      default: ;
    endcase
    return r;
  endfunction

  task automatic offer_item(input logic [CMD_W-1:0] cmd, input logic [OPA_W-1:0] a,
                            input logic [OPB_W-1:0] b, input logic typed,
                            input residue_t typed_value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_operand_a <= a;
    in_operand_b <= b;
    do @(posedge clk); while (in_stall);
    pending_residues.push_back(typed ? typed_value : predict_residue(cmd, a, b, modulus_now));
    items_sent++;
    cmd_count[cmd]++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_residues.size() != 0);
  endtask

  task automatic set_modulus(input logic [RES_W-1:0] value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    modulus_now = value;
    modulus_writes++;
  endtask

  task automatic draw_item(output logic [CMD_W-1:0] cmd, output logic [OPA_W-1:0] a,
                           output logic [OPB_W-1:0] b);
    int sel;
    int fermat_share;
    // Fermat steps are slow on a wide modulus: keep them rare there
    fermat_share = (modulus_now > 31'd65536) ? 4 : 12;
    sel = $urandom_range(99);
    if (sel < fermat_share) cmd = OP_INV;
    else if (sel < 2 * fermat_share) cmd = OP_DIV;
    else if (sel < 44) cmd = OP_POW;
    else if (sel < 58) cmd = OP_MUL;
    else if (sel < 70) cmd = OP_ADD;
    else if (sel < 82) cmd = OP_SUB;
    else if (sel < 94) cmd = OP_NEG;
    else cmd = CMD_UNUSED;

    case ($urandom_range(9))
      0: a = '0;
      1: a = A_MAX;
      2: a = modulus_now - 1'b1;
      3: a = modulus_now;
      4: a = OPA_W'($urandom_range(20));
      default: a = OPA_W'($urandom);
    endcase

    case ($urandom_range(9))
      0: b = '0;
      1: b = B_MAX;
      2: b = OPB_W'(64'(modulus_now) * $urandom_range(32'h7FFF_FFFF));
      3: b = OPB_W'($urandom_range(20));
      default: b = OPB_W'({$urandom, $urandom});
    endcase

    // mostly short exponents, now and then a full-width one
    if (cmd == OP_POW) begin
      case ($urandom_range(39))
        0: b = OPB_W'({$urandom, $urandom});
        1: b = '0;
        default: b = OPB_W'($urandom) & ((OPB_W'(1) << $urandom_range(1, 8)) - 1'b1);
      endcase
    end
  endtask

  // result side: random stall, plus a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != holds_asked) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    residue_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_residues.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transfer: residue %0d error %0b", out_result, out_error);
      end else begin
        want = pending_residues.pop_front();
        if (out_result !== want.residue || out_error !== want.error) begin
          mismatches++;
          if (mismatches <= 10)
            $display("command %0d: expected residue %0d error %0b, got residue %0d error %0b",
                     want.cmd, want.residue, want.error, out_result, out_error);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", quiet_cycles);
      $display("modular_arithmetic_unit_32: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [CMD_W-1:0] cmd;
    logic [OPA_W-1:0] a;
    logic [OPB_W-1:0] b;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_command   <= OP_ADD;
    in_operand_a <= '0;
    in_operand_b <= '0;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    modulus_now = MOD_RESET;

    send_idle_pct = 26;
    recv_idle_pct = 82;
    for (int i = 0; i < NUM_VECTORS; i++) begin
      if (vectors[i].modulus != modulus_now) set_modulus(vectors[i].modulus);
      offer_item(vectors[i].cmd, vectors[i].a, vectors[i].b, vectors[i].typed,
                 {vectors[i].cmd, vectors[i].residue, vectors[i].error});
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_modulus(phase_modulus[p]);
      if (p < 2) begin
        send_idle_pct = 26;
        recv_idle_pct = 82;
      end else if (p < 4) begin
        send_idle_pct = 82;
        recv_idle_pct = 26;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int n = 0; n < phase_items[p]; n++) begin
        // hold the output long enough for the input to back up
        if (n == 20 && (p == 1 || p == 5)) holds_asked++;
        if (n == 100 && p == 4) drain_results();
        draw_item(cmd, a, b);
        offer_item(cmd, a, b, 1'b0, '0);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d items over %0d modulus writes: add %0d sub %0d mul %0d div %0d neg %0d",
             items_sent, modulus_writes, cmd_count[OP_ADD], cmd_count[OP_SUB],
             cmd_count[OP_MUL], cmd_count[OP_DIV], cmd_count[OP_NEG]);
    $display("inv %0d pow %0d unused %0d; %0d results compared, %0d mismatches",
             cmd_count[OP_INV], cmd_count[OP_POW], cmd_count[CMD_UNUSED], results_seen,
             mismatches);
    if (mismatches == 0 && pending_residues.size() == 0) begin
      $display("modular_arithmetic_unit_32: match");
    end else begin
      $display("modular_arithmetic_unit_32: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/mau32_pkg.sv
sv/mau32_dp.sv
sv/mau32_ctrl.sv
sv/modular_arithmetic_unit_32.sv
test/tb_modular_arithmetic_unit_32.sv
